FILE: rtl/ltc_pkg.sv
// Package of the lexeme token classifier: class codes, character codes and the token table.
`timescale 1ns / 1ps

package ltc_pkg;

  localparam int KNOWN_ENTRIES   = 89;
  localparam int WORD_BYTES      = 16;
  localparam int MAX_KEYWORD_LEN = 14;

  typedef logic [6:0]                  class_t;
  typedef logic [7:0]                  char_t;
  typedef logic [WORD_BYTES*8-1:0]     word_t;
  typedef logic [WORD_BYTES-1:0][7:0]  chars_t;

  localparam class_t CLASS_INT    = 7'd89;
  localparam class_t CLASS_FLOAT  = 7'd90;
  localparam class_t CLASS_IDENT  = 7'd91;
  localparam class_t CLASS_STRING = 7'd92;
  localparam class_t CLASS_ERROR  = 7'd93;

  localparam char_t CHAR_DOT        = 8'h2E;
  localparam char_t CHAR_UNDERSCORE = 8'h5F;
  localparam char_t CHAR_DQUOTE     = 8'h22;
  localparam char_t CHAR_SQUOTE     = 8'h27;

  localparam word_t WORD_TABLE [KNOWN_ENTRIES] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if", "int",
    "long", "register", "return", "short", "signed", "sizeof", "static",
    "struct", "switch", "typedef", "union", "unsigned", "void", "volatile",
    "while", "inline", "_Alignas", "_Alignof", "_Atomic", "_Bool",
    "_Complex", "_Generic", "_Imaginary", "_Noreturn", {"_Static", "_assert"},
    {"_Thread", "_local"},
    ";", ":", ",", ".", "=", "+", "-", "*", "/", "<", ">", "(", ")", "{",
    "}", "[", "]", "#", "!", "%", "&", "|", "^", "~", "?",
    "==", "!=", ">=", "<=", "&&", "||", "<<", ">>", "++", "--", "->", "+=",
    "-=", "*=", "/=", "%=", "<<=", ">>=", "&=", "^=", "|="
  };

  // Entries are packed right-aligned, so the length is the count of non-zero bytes.
  function automatic int entry_len(int idx);
    int n;
    n = 0;
    if (idx < KNOWN_ENTRIES) begin
      for (int k = 0; k < WORD_BYTES; k++) begin
        if (WORD_TABLE[idx][k*8 +: 8] != 8'h00) begin
          n++;
        end
      end
    end
    return n;
  endfunction

  // Returns the characters of an entry with the first character at index zero.
  function automatic chars_t entry_chars(int idx);
    int     len;
    chars_t c;
    c   = '0;
    len = entry_len(idx);
    for (int k = 0; k < len; k++) begin
      c[k] = WORD_TABLE[idx][(len-1-k)*8 +: 8];
    end
    return c;
  endfunction

endpackage

FILE: rtl/ltc_if.sv
// Valid/ready channel interfaces for the characters and the token classes.
`timescale 1ns / 1ps

interface ltc_in_if;
  logic          valid;
  logic          ready;
  ltc_pkg::char_t ch;
  logic          last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ltc_out_if;
  logic            valid;
  logic            ready;
  ltc_pkg::class_t token_class;

  modport source (output valid, output token_class, input ready);
  modport sink   (input valid, input token_class, output ready);
endinterface

FILE: rtl/lexeme_token_classifier_unit.sv
// Top level of the lexeme token classifier: input register, match state and result register.
// The class of a final character is taken from the input register into the result register,
// which offers it on the result channel.
// Throughput: one character per cycle; the input register stalls only on a final
// character while the result register holds a class that has not been taken.
// Reset: synchronous, active low; empties both registers and returns all match
// state to its start values, as does every final character.
`timescale 1ns / 1ps

module lexeme_token_classifier_unit #(
  parameter int TABLE_ENTRIES = 89
) (
  input  logic      clk,
  input  logic      rst_n,
  ltc_in_if.sink    in_chan,
  ltc_out_if.source out_chan
);

  logic                     s1_valid_r;
  ltc_pkg::char_t           s1_ch_r;
  logic                     s1_last_r;
  logic                     s1_fire;

  logic [TABLE_ENTRIES-1:0] alive_r;
  logic [TABLE_ENTRIES-1:0] alive_nxt;
  logic [TABLE_ENTRIES-1:0] match;
  logic [3:0]               pos_r;
  logic [3:0]               pos_nxt;
  logic [4:0]               pos_plus1;
  logic                     number_ok_r, number_ok_nxt;
  logic                     float_seen_r, float_seen_nxt;
  logic                     ident_ok_r, ident_ok_nxt;
  ltc_pkg::char_t           first_r, first_nxt;
  ltc_pkg::char_t           prev_r;

  logic                     out_valid_r;
  ltc_pkg::class_t          class_r;
  ltc_pkg::class_t          class_nxt;
  ltc_pkg::class_t          match_idx;

  logic                     ch_digit, ch_alpha, ch_word, prev_digit, first_alpha;

  assign s1_fire       = s1_valid_r && (!s1_last_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_fire;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.token_class = class_r;

  assign ch_digit   = (s1_ch_r >= "0") && (s1_ch_r <= "9");
  assign ch_alpha   = ((s1_ch_r >= "a") && (s1_ch_r <= "z")) ||
                      ((s1_ch_r >= "A") && (s1_ch_r <= "Z"));
  assign ch_word    = ch_alpha || ch_digit || (s1_ch_r == ltc_pkg::CHAR_UNDERSCORE);
  assign prev_digit = (prev_r >= "0") && (prev_r <= "9");
  assign pos_plus1  = {1'b0, pos_r} + 5'd1;
  assign pos_nxt    = (pos_r == 4'hF) ? pos_r : pos_plus1[3:0];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
    localparam int              LEN   = ltc_pkg::entry_len(i);
    localparam logic [4:0]      LEN5  = 5'(LEN);
    localparam ltc_pkg::chars_t CHARS = ltc_pkg::entry_chars(i);
    localparam logic            FITS  = (LEN > 0) && (LEN <= ltc_pkg::MAX_KEYWORD_LEN);

    assign alive_nxt[i] = alive_r[i] && ({1'b0, pos_r} < LEN5) && (CHARS[pos_r] == s1_ch_r);
    assign match[i]     = FITS && alive_nxt[i] && (LEN5 == pos_plus1);
  end

  always_comb begin
    number_ok_nxt  = number_ok_r;
    float_seen_nxt = float_seen_r;
    if (!ch_digit) begin
      if ((s1_ch_r == ltc_pkg::CHAR_DOT) && number_ok_r && (pos_r != 4'd0) && prev_digit) begin
        float_seen_nxt = 1'b1;
      end else begin
        number_ok_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    first_nxt    = first_r;
    ident_ok_nxt = ident_ok_r;
    if (pos_r == 4'd0) begin
      first_nxt    = s1_ch_r;
      ident_ok_nxt = ch_alpha || (s1_ch_r == ltc_pkg::CHAR_UNDERSCORE);
    end else if (!ch_word) begin
      ident_ok_nxt = 1'b0;
    end
  end

  assign first_alpha = ((first_nxt >= "a") && (first_nxt <= "z")) ||
                       ((first_nxt >= "A") && (first_nxt <= "Z")) ||
                       (first_nxt == ltc_pkg::CHAR_UNDERSCORE);

  // Table entries are distinct, so at most one entry matches and the index is an OR of all.
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (match[i]) begin
        match_idx = match_idx | 7'(i);
      end
    end
  end

  always_comb begin
    if (|match) begin
      class_nxt = match_idx;
    end else if (number_ok_nxt) begin
      class_nxt = float_seen_nxt ? ltc_pkg::CLASS_FLOAT : ltc_pkg::CLASS_INT;
    end else if (first_alpha) begin
      class_nxt = ident_ok_nxt ? ltc_pkg::CLASS_IDENT : ltc_pkg::CLASS_ERROR;
    end else if ((first_nxt == ltc_pkg::CHAR_DQUOTE) && (s1_ch_r == ltc_pkg::CHAR_DQUOTE)) begin
      class_nxt = ltc_pkg::CLASS_STRING;
    end else if ((first_nxt == ltc_pkg::CHAR_SQUOTE) && (s1_ch_r == ltc_pkg::CHAR_SQUOTE)) begin
      class_nxt = ltc_pkg::CLASS_INT;
    end else begin
      class_nxt = ltc_pkg::CLASS_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      alive_r      <= '1;
      pos_r        <= '0;
      number_ok_r  <= 1'b1;
      float_seen_r <= 1'b0;
      ident_ok_r   <= 1'b1;
      first_r      <= '0;
      prev_r       <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        if (s1_last_r) begin
          out_valid_r  <= 1'b1;
          alive_r      <= '1;
          pos_r        <= '0;
          number_ok_r  <= 1'b1;
          float_seen_r <= 1'b0;
          ident_ok_r   <= 1'b1;
          first_r      <= '0;
          prev_r       <= '0;
        end else begin
          alive_r      <= alive_nxt;
          pos_r        <= pos_nxt;
          number_ok_r  <= number_ok_nxt;
          float_seen_r <= float_seen_nxt;
          ident_ok_r   <= ident_ok_nxt;
          first_r      <= first_nxt;
          prev_r       <= s1_ch_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_ch_r   <= in_chan.ch;
      s1_last_r <= in_chan.last;
    end
    if (s1_fire && s1_last_r) begin
      class_r <= class_nxt;
    end
  end

endmodule

FILE: rtl/ltc_checker.sv
// Port-level checks of the lexeme token classifier and their binding to the top level.
`timescale 1ns / 1ps

module ltc_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input ltc_pkg::class_t token_class
);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result channel not empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_class))
    else $error("pending result changed before its transfer");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> token_class <= ltc_pkg::CLASS_ERROR)
    else $error("token class out of range");

endmodule

bind lexeme_token_classifier_unit ltc_checker u_ltc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .token_class (out_chan.token_class)
);

FILE: verif/lexeme_token_classifier_unit_tb.sv
// Testbench of the lexeme token classifier: streams lexemes through the block and checks every class.
`timescale 1ns / 1ps

class lexeme_tracker;
  string               c_words[$];
  bit [ltc_pkg::KNOWN_ENTRIES-1:0] alive;
  int unsigned         position;
  bit                  number_ok;
  bit                  float_seen;
  bit                  ident_ok;
  ltc_pkg::char_t      first_char;
  ltc_pkg::char_t      prev_char;
  ltc_pkg::class_t     pending_classes[$];
  int                  errors;

  function new();
    c_words = '{
      "auto", "break", "case", "char", "const", "continue", "default", "do",
      "double", "else", "enum", "extern", "float", "for", "goto", "if", "int",
      "long", "register", "return", "short", "signed", "sizeof", "static",
      "struct", "switch", "typedef", "union", "unsigned", "void", "volatile",
      "while", "inline", "_Alignas", "_Alignof", "_Atomic", "_Bool",
      "_Complex", "_Generic", "_Imaginary", "_Noreturn", {"_Static", "_assert"},
      {"_Thread", "_local"},
      ";", ":", ",", ".", "=", "+", "-", "*", "/", "<", ">", "(", ")", "{",
      "}", "[", "]", "#", "!", "%", "&", "|", "^", "~", "?",
      "==", "!=", ">=", "<=", "&&", "||", "<<", ">>", "++", "--", "->", "+=",
      "-=", "*=", "/=", "%=", "<<=", ">>=", "&=", "^=", "|="
    };
    errors = 0;
    start_lexeme();
  endfunction

  function void start_lexeme();
    alive      = '1;
    position   = 0;
    number_ok  = 1'b1;
    float_seen = 1'b0;
    ident_ok   = 1'b1;
    first_char = '0;
    prev_char  = '0;
  endfunction

  function bit is_digit(ltc_pkg::char_t c);
    return c >= "0" && c <= "9";
  endfunction

  function bit is_alpha(ltc_pkg::char_t c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Updates the running match state with one transferred character and, on the
  // final character, queues the class that the block must give.
  function void classify_char(ltc_pkg::char_t c, logic fin);
    int unsigned     p;
    int unsigned     len;
    bit              found;
    bit              word_char;
    ltc_pkg::class_t cls;
    p         = position;
    word_char = is_alpha(c) || is_digit(c) || c == ltc_pkg::CHAR_UNDERSCORE;
    for (int i = 0; i < ltc_pkg::KNOWN_ENTRIES; i++) begin
      len = c_words[i].len();
      if (alive[i] && (p >= len || ltc_pkg::char_t'(c_words[i][p]) != c)) begin
        alive[i] = 1'b0;
      end
    end
    if (!is_digit(c)) begin
      if (c == ltc_pkg::CHAR_DOT && number_ok && p != 0 && is_digit(prev_char)) begin
        float_seen = 1'b1;
      end else begin
        number_ok = 1'b0;
      end
    end
    if (p == 0) begin
      first_char = c;
      ident_ok   = is_alpha(c) || c == ltc_pkg::CHAR_UNDERSCORE;
    end else if (!word_char) begin
      ident_ok = 1'b0;
    end
    prev_char = c;
    if (position < 15) begin
      position++;
    end
    if (!fin) begin
      return;
    end
    found = 1'b0;
    cls   = ltc_pkg::CLASS_ERROR;
    for (int i = 0; i < ltc_pkg::KNOWN_ENTRIES; i++) begin
      len = c_words[i].len();
      if (!found && alive[i] && len == p + 1 && len <= ltc_pkg::MAX_KEYWORD_LEN) begin
        cls   = ltc_pkg::class_t'(i);
        found = 1'b1;
      end
    end
    if (!found) begin
      if (number_ok) begin
        cls = float_seen ? ltc_pkg::CLASS_FLOAT : ltc_pkg::CLASS_INT;
      end else if (is_alpha(first_char) || first_char == ltc_pkg::CHAR_UNDERSCORE) begin
        cls = ident_ok ? ltc_pkg::CLASS_IDENT : ltc_pkg::CLASS_ERROR;
      end else if (first_char == ltc_pkg::CHAR_DQUOTE && c == ltc_pkg::CHAR_DQUOTE) begin
        cls = ltc_pkg::CLASS_STRING;
      end else if (first_char == ltc_pkg::CHAR_SQUOTE && c == ltc_pkg::CHAR_SQUOTE) begin
        cls = ltc_pkg::CLASS_INT;
      end else begin
        cls = ltc_pkg::CLASS_ERROR;
      end
    end
    pending_classes.push_back(cls);
    start_lexeme();
  endfunction

  function void check_class(ltc_pkg::class_t got);
    ltc_pkg::class_t want;
    if (pending_classes.size() == 0) begin
      $display("%0t: token class %0d transferred with none expected", $time, got);
      errors++;
      return;
    end
    want = pending_classes.pop_front();
    if (got !== want) begin
      $display("%0t: token class mismatch, expected %0d, actual %0d", $time, want, got);
      errors++;
    end
  endfunction

  function int pending();
    return pending_classes.size();
  endfunction
endclass

module lexeme_token_classifier_unit_tb;

  logic clk;
  logic rst_n;

  ltc_in_if  in_chan ();
  ltc_out_if out_chan ();

  lexeme_token_classifier_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  lexeme_tracker tracker = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned chars_sent;
  logic        hold_request;
  logic        hold_started = 1'b0;
  int unsigned hold_count = 0;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // The receiver stalls at random, and once holds off for a long stretch so
  // that the block fills up and stalls the character channel.
  always @(posedge clk) begin
    if (hold_request && !hold_started) begin
      hold_started  <= 1'b1;
      hold_count    <= 80;
      out_chan.ready <= 1'b0;
    end else if (hold_count != 0) begin
      hold_count     <= hold_count - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        tracker.classify_char(in_chan.ch, in_chan.last);
      end
      if (out_chan.valid && out_chan.ready) begin
        tracker.check_class(out_chan.token_class);
      end
    end
  end

  task automatic push_char(input ltc_pkg::char_t c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.ch    <= c;
    in_chan.last  <= fin;
    @(posedge clk);
    while (!in_chan.ready) begin
      @(posedge clk);
    end
    chars_sent++;
  endtask

  task automatic send_lexeme(input ltc_pkg::char_t chars[$]);
    foreach (chars[k]) begin
      push_char(chars[k], k == chars.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    ltc_pkg::char_t chars[$];
    for (int k = 0; k < s.len(); k++) begin
      chars.push_back(ltc_pkg::char_t'(s[k]));
    end
    send_lexeme(chars);
  endtask

  function automatic ltc_pkg::char_t random_word_char();
    case ($urandom_range(3))
      0: return ltc_pkg::char_t'("a" + $urandom_range(25));
      1: return ltc_pkg::char_t'("A" + $urandom_range(25));
      2: return ltc_pkg::char_t'("0" + $urandom_range(9));
      default: return ltc_pkg::CHAR_UNDERSCORE;
    endcase
  endfunction

  // Builds one lexeme of a randomly chosen kind, mostly well formed.
  task automatic send_random_lexeme();
    ltc_pkg::char_t chars[$];
    string          word;
    int unsigned    kind;
    int unsigned    len;
    int unsigned    pos;
    kind = $urandom_range(99);
    if (kind < 25) begin
      send_text(tracker.c_words[$urandom_range(ltc_pkg::KNOWN_ENTRIES - 1)]);
      return;
    end
    if (kind < 35) begin
      word = tracker.c_words[$urandom_range(ltc_pkg::KNOWN_ENTRIES - 1)];
      for (int k = 0; k < word.len(); k++) begin
        chars.push_back(ltc_pkg::char_t'(word[k]));
      end
      case ($urandom_range(2))
        0: if (chars.size() > 1) void'(chars.pop_back());
        1: chars.push_back(ltc_pkg::char_t'($urandom_range(127)));
        default: begin
          pos        = $urandom_range(chars.size() - 1);
          chars[pos] = ltc_pkg::char_t'($urandom_range(127));
        end
      endcase
    end else if (kind < 50) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        chars.push_back(($urandom_range(99) < 80) ? ltc_pkg::char_t'("0" + $urandom_range(9))
                                                  : ltc_pkg::CHAR_DOT);
      end
    end else if (kind < 65) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 10);
      chars.push_back(($urandom_range(3) == 0) ? ltc_pkg::CHAR_UNDERSCORE
                                                : ltc_pkg::char_t'("a" + $urandom_range(25)));
      for (int k = 1; k < len; k++) begin
        chars.push_back(random_word_char());
      end
    end else if (kind < 73) begin
      len = $urandom_range(0, 6);
      chars.push_back(ltc_pkg::CHAR_DQUOTE);
      for (int k = 0; k < len; k++) begin
        chars.push_back(ltc_pkg::char_t'($urandom_range(32, 126)));
      end
      chars.push_back(($urandom_range(5) == 0) ? ltc_pkg::char_t'($urandom_range(255))
                                               : ltc_pkg::CHAR_DQUOTE);
    end else if (kind < 78) begin
      chars.push_back(ltc_pkg::CHAR_SQUOTE);
      chars.push_back(ltc_pkg::char_t'($urandom_range(32, 126)));
      chars.push_back(($urandom_range(5) == 0) ? ltc_pkg::char_t'($urandom_range(255))
                                               : ltc_pkg::CHAR_SQUOTE);
    end else if (kind < 90) begin
      len = $urandom_range(1, 18);
      for (int k = 0; k < len; k++) begin
        chars.push_back(ltc_pkg::char_t'($urandom_range(255)));
      end
    end else begin
      len = $urandom_range(2, 8);
      for (int k = 0; k < len; k++) begin
        chars.push_back(random_word_char());
      end
      pos        = $urandom_range(len - 1);
      chars[pos] = ltc_pkg::char_t'($urandom_range(255));
    end
    send_lexeme(chars);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    ltc_pkg::char_t odd_bytes[$];
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.ch     = '0;
    in_chan.last   = 1'b0;
    hold_request   = 1'b0;
    chars_sent     = 0;
    send_idle_pct  = 22;
    recv_idle_pct  = 52;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("<<=");
    send_text({"_Static", "_assert"});
    send_text("\"");
    send_text("'");
    send_text("7");
    send_text("1.5");
    send_text(".5");
    send_text("a_9");
    send_text("'x'");
    odd_bytes = '{8'hFF};
    send_lexeme(odd_bytes);
    odd_bytes = '{8'h00};
    send_lexeme(odd_bytes);
    odd_bytes = '{"x", 8'h80};
    send_lexeme(odd_bytes);

    while (chars_sent < 200) begin
      if (chars_sent > 80 && !hold_request) begin
        hold_request <= 1'b1;
      end
      send_random_lexeme();
    end
    wait_drained();
    send_idle_pct <= 52;
    recv_idle_pct <= 22;
    while (chars_sent < 400) begin
      send_random_lexeme();
    end
    wait_drained();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    while (chars_sent < 600) begin
      send_random_lexeme();
    end
    wait_drained();
    repeat (10) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
